// ----- design/bop_pkg.sv -----
// shared types and constants for the binomial option pricer
// used by bop_cell, bop_leaf_gen and binomial_option_pricer
package bop_pkg;

   localparam int unsigned PriceWidth = 32;
   localparam int unsigned ProbWidth  = 31;
   localparam int unsigned StepWidth  = 9;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned FracBits   = 30;

   localparam logic [ProbWidth-1:0] OneQ30 = 31'h4000_0000;

   localparam logic [CsrIdxWidth-1:0] CSR_STRIKE   = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_DOWN     = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_UP_DOWN  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_PROB     = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_DISCOUNT = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_STEPS    = 3'd5;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DOWN = 5'b00010,
      ST_LEAF = 5'b00100,
      ST_FOLD = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic                  fold;
      logic [ProbWidth-1:0]  p;
      logic [ProbWidth-1:0]  q;
      logic [PriceWidth-1:0] leaf;
   } cell_ctl_type;

endpackage

// ----- design/bop_cell.sv -----
// one lattice cell: holds a node value, loads a leaf or folds with its neighbour
// depends on bop_pkg
module bop_cell (
   input  logic                               clock,
   input  bop_pkg::cell_ctl_type              ctl,
   input  logic                               load,
   input  logic [bop_pkg::PriceWidth-1:0]     neighbour,
   output logic [bop_pkg::PriceWidth-1:0]     value
);

   logic [bop_pkg::PriceWidth-1:0] value_ff;
   logic [bop_pkg::PriceWidth-1:0] value_in;
   logic [62:0]                    prod_q;
   logic [62:0]                    prod_p;
   logic [63:0]                    acc;

   always_comb begin
      prod_q = 63'(value_ff) * 63'(ctl.q);
      prod_p = 63'(neighbour) * 63'(ctl.p);
      acc    = 64'(prod_q) + 64'(prod_p);
      if (ctl.fold) begin
         value_in = acc[61:30];
      end else if (load) begin
         value_in = ctl.leaf;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ----- design/bop_leaf_gen.sv -----
// leaf price generator: repeated scaled multiply with clamp, and call payoff
// depends on bop_pkg
module bop_leaf_gen (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           init,
   input  logic                           step,
   input  logic [bop_pkg::PriceWidth-1:0] spot,
   input  logic [bop_pkg::PriceWidth-1:0] factor,
   input  logic [bop_pkg::PriceWidth-1:0] strike,
   output logic [bop_pkg::PriceWidth-1:0] payoff,
   output logic                           saturated
);

   logic [bop_pkg::PriceWidth-1:0] x_ff;
   logic [bop_pkg::PriceWidth-1:0] x_in;
   logic                           sat_ff;
   logic                           sat_in;
   logic [63:0]                    prod;
   logic [33:0]                    scaled;

   always_comb begin
      prod   = 64'(x_ff) * 64'(factor);
      scaled = prod[63:30];
      x_in   = x_ff;
      sat_in = sat_ff;
      if (init) begin
         x_in   = spot;
         sat_in = 1'b0;
      end else if (step) begin
         if (scaled[33:32] != 2'b00) begin
            x_in   = '1;
            sat_in = 1'b1;
         end else begin
            x_in = scaled[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      if (reset) begin
         sat_ff <= 1'b0;
      end else begin
         sat_ff <= sat_in;
      end
   end

   assign payoff    = (x_ff > strike) ? (x_ff - strike) : '0;
   assign saturated = sat_ff;

endmodule

// ----- design/binomial_option_pricer.sv -----
// binomial option pricer, European call by backward induction
// top level: register file, sequencer, leaf generator and row of cells
// depends on bop_pkg, bop_cell, bop_leaf_gen
//
// usage:
//   raise start with req_spot_price while busy is low; the transaction is
//   taken on that edge and busy goes high on the next cycle.
//   with m = min(step_count, MAX_STEPS) the sequencer scales spot down to
//   leaf 0, writes leaves into cells 0..m, folds the row down to the root in
//   cell 0 (every cell folds with its upper neighbour in the same cycle) and
//   discounts the root. the next start is taken in the cycle in which the
//   result appears; a new request is not taken before the last one is done.
//   rsp_valid is high for one cycle with rsp_option_value and rsp_saturated;
//   there is no back-pressure, the receiver must take it then.
//   csr writes take effect at once; make them only while busy is low, the block does not enforce it.
//   reset returns the registers to their defaults and the sequencer to idle;
//   the cells hold no state of interest between requests.
module binomial_option_pricer #(
   parameter int unsigned MAX_STEPS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [bop_pkg::PriceWidth-1:0]      req_spot_price,
   output logic                                rsp_valid,
   output logic [bop_pkg::PriceWidth-1:0]      rsp_option_value,
   output logic                                rsp_saturated,
   input  logic                                csr_write_enable,
   input  logic [bop_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [bop_pkg::PriceWidth-1:0]      csr_write_data
);

   localparam int unsigned CW = $clog2(MAX_STEPS + 1);

   logic [bop_pkg::PriceWidth-1:0] strike_ff, down_ff, up_down_ff;
   logic [bop_pkg::ProbWidth-1:0]  prob_ff, disc_ff;
   logic [bop_pkg::StepWidth-1:0]  steps_ff;

   bop_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] m;
   logic [bop_pkg::ProbWidth-1:0] p_eff, disc_eff;

   logic                           gen_init, gen_step;
   logic [bop_pkg::PriceWidth-1:0] gen_factor, gen_payoff;
   logic                           gen_sat;

   bop_pkg::cell_ctl_type          ctl;
   logic [bop_pkg::PriceWidth-1:0] cell_value [MAX_STEPS+1];

   logic                           rsp_valid_ff;
   logic [bop_pkg::PriceWidth-1:0] rsp_value_ff;
   logic                           rsp_sat_ff;
   logic [62:0]                    root_prod;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         strike_ff  <= '0;
         down_ff    <= 32'h4000_0000;
         up_down_ff <= 32'h4000_0000;
         prob_ff    <= 31'h2000_0000;
         disc_ff    <= bop_pkg::OneQ30;
         steps_ff   <= 9'd1;
      end else if (csr_write_enable) begin
         case (csr_index)
            bop_pkg::CSR_STRIKE:   strike_ff  <= csr_write_data;
            bop_pkg::CSR_DOWN:     down_ff    <= csr_write_data;
            bop_pkg::CSR_UP_DOWN:  up_down_ff <= csr_write_data;
            bop_pkg::CSR_PROB:     prob_ff    <= csr_write_data[30:0];
            bop_pkg::CSR_DISCOUNT: disc_ff    <= csr_write_data[30:0];
            bop_pkg::CSR_STEPS:    steps_ff   <= csr_write_data[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (32'(steps_ff) > 32'(MAX_STEPS)) begin
         m = CW'(MAX_STEPS);
      end else begin
         m = CW'(steps_ff);
      end
      p_eff    = (prob_ff > bop_pkg::OneQ30) ? bop_pkg::OneQ30 : prob_ff;
      disc_eff = (disc_ff > bop_pkg::OneQ30) ? bop_pkg::OneQ30 : disc_ff;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      gen_init   = 1'b0;
      gen_step   = 1'b0;
      gen_factor = down_ff;
      ctl.fold   = 1'b0;
      case (state_ff)
         bop_pkg::ST_IDLE: begin
            if (start) begin
               gen_init = 1'b1;
               cnt_in   = '0;
               state_in = (m == '0) ? bop_pkg::ST_LEAF : bop_pkg::ST_DOWN;
            end
         end
         bop_pkg::ST_DOWN: begin
            gen_step = 1'b1;
            if (cnt_ff == m - CW'(1)) begin
               cnt_in   = '0;
               state_in = bop_pkg::ST_LEAF;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         bop_pkg::ST_LEAF: begin
            gen_factor = up_down_ff;
            if (cnt_ff == m) begin
               cnt_in   = '0;
               state_in = (m == '0) ? bop_pkg::ST_DONE : bop_pkg::ST_FOLD;
            end else begin
               gen_step = 1'b1;
               cnt_in   = cnt_ff + CW'(1);
            end
         end
         bop_pkg::ST_FOLD: begin
            ctl.fold = 1'b1;
            if (cnt_ff == m - CW'(1)) begin
               cnt_in   = '0;
               state_in = bop_pkg::ST_DONE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         bop_pkg::ST_DONE: begin
            state_in = bop_pkg::ST_IDLE;
         end
         default: begin
            state_in = bop_pkg::ST_IDLE;
         end
      endcase
      ctl.p    = p_eff;
      ctl.q    = bop_pkg::OneQ30 - p_eff;
      ctl.leaf = gen_payoff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bop_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   bop_leaf_gen u_leaf_gen (
      .clock     (clock),
      .reset     (reset),
      .init      (gen_init),
      .step      (gen_step),
      .spot      (req_spot_price),
      .factor    (gen_factor),
      .strike    (strike_ff),
      .payoff    (gen_payoff),
      .saturated (gen_sat)
   );

   // row of cells; the top cell folds with zero, its result is never used
   for (genvar i = 0; i <= MAX_STEPS; i++) begin : g_cell
      logic [bop_pkg::PriceWidth-1:0] nb;
      logic                           ld;
      if (i == MAX_STEPS) begin : g_top
         assign nb = '0;
      end else begin : g_mid
         assign nb = cell_value[i+1];
      end
      assign ld = (state_ff == bop_pkg::ST_LEAF) && (cnt_ff == CW'(i));
      bop_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load      (ld),
         .neighbour (nb),
         .value     (cell_value[i])
      );
   end

   assign root_prod = 63'(cell_value[0]) * 63'(disc_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == bop_pkg::ST_DONE);
      end
      rsp_value_ff <= root_prod[61:30];
      rsp_sat_ff   <= gen_sat;
   end

   assign busy             = (state_ff != bop_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_option_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

// ----- design/bop_checker.sv -----
// port-level checks on the request/response sequencing of the pricer
// depends on binomial_option_pricer, bound to it below
module bop_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // an accepted transaction makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after accepted start");

   // a result strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // result comes out as the block returns to idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while still busy");

   a_end_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

endmodule

bind binomial_option_pricer bop_checker u_bop_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
